>>> rtl/encoder_position_drive_assert.svh
// ----------------------------------------------------------------------------
// encoder_position_drive_assert.svh
// Assertion macros for the encoder position drive; empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ENCODER_POSITION_DRIVE_ASSERT_SVH
`define ENCODER_POSITION_DRIVE_ASSERT_SVH

`ifndef SYNTHESIS
`define EPD_ASSERT_COMB(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("encoder_position_drive: check failed");
`define EPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("encoder_position_drive: check failed");
`else
`define EPD_ASSERT_COMB(label, expr)
`define EPD_ASSERT_IMPL(label, ante, cons)
`endif

`endif

>>> rtl/epd_pkg.sv
// ----------------------------------------------------------------------------
// epd_pkg
// Shared types, register codes and reset values of the encoder position drive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package epd_pkg;

    localparam logic [2:0] CFG_RANGE_LOW     = 3'd0;
    localparam logic [2:0] CFG_RANGE_HIGH    = 3'd1;
    localparam logic [2:0] CFG_DEADBAND      = 3'd2;
    localparam logic [2:0] CFG_DRIVE_FLOOR   = 3'd3;
    localparam logic [2:0] CFG_DRIVE_CEILING = 3'd4;
    localparam logic [2:0] CFG_HOMING_DRIVE  = 3'd5;

    localparam logic [15:0] RST_RANGE_LOW     = 16'd30000;
    localparam logic [15:0] RST_RANGE_HIGH    = 16'd52116;
    localparam logic [7:0]  RST_DEADBAND      = 8'd5;
    localparam logic [15:0] RST_DRIVE_FLOOR   = 16'd500;
    localparam logic [15:0] RST_DRIVE_CEILING = 16'd1000;
    localparam logic [15:0] RST_HOMING_DRIVE  = 16'd700;

    localparam logic [1:0] MOTION_STOP = 2'd0;
    localparam logic [1:0] MOTION_DOWN = 2'd1;
    localparam logic [1:0] MOTION_UP   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [15:0] drive_down;
        logic [15:0] drive_up;
        logic        count_load;
        logic [15:0] count_load_value;
        logic        settled;
        logic [1:0]  motion;
    } t_res;

    // word handed from front to back through the queue
    typedef struct packed {
        t_res        res;
        logic        prop;
        logic        dir_up;
        logic [15:0] err;
    } t_cmd;

    // what rides along the back divider
    typedef struct packed {
        t_res res;
        logic prop;
        logic dir_up;
    } t_back_tag;

    // what rides along the scaling pipeline
    typedef struct packed {
        logic [15:0] count;
        logic        low_open;
        logic        high_open;
        logic        home_low;
        logic        home_high;
        logic        neg;
    } t_front_tag;

    function automatic logic [15:0] f_abs_diff(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] d;
        d = {1'b0, a} - {1'b0, b};
        f_abs_diff = d[16] ? 16'(~d + 17'd1) : d[15:0];
    endfunction

endpackage

>>> rtl/epd_div.sv
// ----------------------------------------------------------------------------
// epd_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epd_div #(
    parameter int NW = 24,
    parameter int DW = 8,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [NW-1:0] o_quot,
    output logic [TW-1:0] o_tag
);

    logic          r_v   [NW];
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [DW-1:0] r_den [NW];
    logic [TW-1:0] r_tag [NW];

    for (genvar gs = 0; gs < NW; gs++) begin : g_stage
        logic          w_v;
        logic [DW-1:0] w_rem;
        logic [DW-1:0] w_den;
        logic [NW-1:0] w_num;
        logic [TW-1:0] w_tag;
        logic [DW:0]   w_shift;
        logic [DW:0]   w_trial;

        if (gs == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_rem = '0;
            assign w_den = i_den;
            assign w_num = i_num;
            assign w_tag = i_tag;
        end else begin : g_next
            assign w_v   = r_v[gs-1];
            assign w_rem = r_rem[gs-1];
            assign w_den = r_den[gs-1];
            assign w_num = r_num[gs-1];
            assign w_tag = r_tag[gs-1];
        end

        // shift in the next numerator bit, keep the difference when it fits
        assign w_shift = {w_rem, w_num[NW-1]};
        assign w_trial = w_shift - {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gs] <= 1'b0;
            end else if (i_en) begin
                r_v[gs] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gs] <= w_trial[DW] ? w_shift[DW-1:0] : w_trial[DW-1:0];
                r_num[gs] <= {w_num[NW-2:0], ~w_trial[DW]};
                r_den[gs] <= w_den;
                r_tag[gs] <= w_tag;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quot  = r_num[NW-1];
    assign o_tag   = r_tag[NW-1];

endmodule

>>> rtl/epd_front.sv
// ----------------------------------------------------------------------------
// epd_front
// Accepts words, scales the target into encoder counts and classifies them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epd_front #(
    parameter int POSITION_STEPS = 250
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_target_position,
    input  logic [15:0]        i_encoder_count,
    input  logic               i_low_switch_open,
    input  logic               i_high_switch_open,
    input  logic [15:0]        i_range_low,
    input  logic [15:0]        i_range_high,
    input  logic [7:0]         i_deadband,
    input  logic [15:0]        i_drive_ceiling,
    input  logic [15:0]        i_homing_drive,
    input  logic [15:0]        i_span,
    input  logic               i_q_full,
    output logic               o_push,
    output epd_pkg::t_cmd      o_cmd
);

    localparam logic [7:0]  STEPS   = 8'(POSITION_STEPS);
    // rounded-up reciprocal of the step count; exact floor for any 24-bit product
    localparam int          RECIP_L = $clog2(POSITION_STEPS);
    localparam int          RECIP_S = 24 + RECIP_L;
    localparam logic [24:0] RECIP   = 25'(((64'd1 << RECIP_S) + 64'(POSITION_STEPS) - 64'd1)
                                          / 64'(POSITION_STEPS));

    logic                  fe;
    logic [16:0]           w_diff;
    epd_pkg::t_front_tag   w_f0_tag;

    logic                  r_f0_v;
    logic [23:0]           r_f0_num;
    epd_pkg::t_front_tag   r_f0_tag;

    logic [56:0]           w_recip_prod;
    logic                  r_f1_v;
    logic [23:0]           r_f1_q;
    epd_pkg::t_front_tag   r_f1_tag;
    logic [25:0]           w_q26;
    logic [25:0]           n_scaled;

    logic                  r_f2_v;
    logic [25:0]           r_scaled;
    epd_pkg::t_front_tag   r_f2_tag;

    logic [25:0]           w_cnt;
    logic [25:0]           w_cnt_hi;
    logic [25:0]           w_cnt_lo;
    logic                  w_up_req;
    logic                  w_dn_req;
    logic [25:0]           w_err;
    logic                  w_big;
    epd_pkg::t_cmd         w_cmd;

    // hold the whole front while a finished word waits on a full queue
    assign fe      = !(r_f2_v && i_q_full);
    assign o_stall = !fe;

    assign w_diff = {1'b0, i_range_high} - {1'b0, i_range_low};

    always_comb begin
        w_f0_tag.count     = i_encoder_count;
        w_f0_tag.low_open  = i_low_switch_open;
        w_f0_tag.high_open = i_high_switch_open;
        w_f0_tag.home_low  = (i_target_position == 8'd0);
        w_f0_tag.home_high = (i_target_position == STEPS);
        w_f0_tag.neg       = w_diff[16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_v <= 1'b0;
        end else if (fe) begin
            r_f0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_f0_num <= i_target_position
                        * epd_pkg::f_abs_diff(i_range_high, i_range_low);
            r_f0_tag <= w_f0_tag;
        end
    end

    // divide by the step count as multiply and shift
    assign w_recip_prod = 57'(r_f0_num) * 57'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (fe) begin
            r_f1_v <= r_f0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_f1_q   <= w_recip_prod[RECIP_S+23:RECIP_S];
            r_f1_tag <= r_f0_tag;
        end
    end

    assign w_q26    = {2'b00, r_f1_q};
    // quotient of the magnitude, so the sign goes on after: truncates toward zero
    assign n_scaled = {10'd0, i_range_low} + (r_f1_tag.neg ? (~w_q26 + 26'd1) : w_q26);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (fe) begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_scaled <= n_scaled;
            r_f2_tag <= r_f1_tag;
        end
    end

    assign w_cnt    = {10'd0, r_f2_tag.count};
    assign w_cnt_hi = w_cnt + {18'd0, i_deadband};
    assign w_cnt_lo = w_cnt - {18'd0, i_deadband};
    assign w_up_req = $signed(w_cnt_hi) < $signed(r_scaled);
    assign w_dn_req = $signed(w_cnt_lo) >= $signed(r_scaled);
    assign w_err    = w_up_req ? (r_scaled - w_cnt) : (w_cnt - r_scaled);
    assign w_big    = (i_span == 16'd0) || (w_err >= {10'd0, i_span});

    always_comb begin
        w_cmd = '0;
        if (r_f2_tag.home_low) begin
            if (!r_f2_tag.low_open) begin
                w_cmd.res.count_load       = 1'b1;
                w_cmd.res.count_load_value = i_range_low;
                w_cmd.res.settled          = 1'b1;
            end else begin
                w_cmd.res.drive_down = i_homing_drive;
                w_cmd.res.motion     = epd_pkg::MOTION_DOWN;
            end
        end else if (r_f2_tag.home_high) begin
            if (!r_f2_tag.high_open) begin
                w_cmd.res.count_load       = 1'b1;
                w_cmd.res.count_load_value = i_range_high;
                w_cmd.res.settled          = 1'b1;
            end else begin
                w_cmd.res.drive_up = i_homing_drive;
                w_cmd.res.motion   = epd_pkg::MOTION_UP;
            end
        end else if (w_up_req) begin
            if (!r_f2_tag.high_open) begin
                w_cmd.res.count_load       = 1'b1;
                w_cmd.res.count_load_value = i_range_high;
                w_cmd.res.settled          = 1'b1;
            end else begin
                w_cmd.res.motion = epd_pkg::MOTION_UP;
                w_cmd.dir_up     = 1'b1;
                if (w_big) begin
                    w_cmd.res.drive_up = i_drive_ceiling;
                end else begin
                    w_cmd.prop = 1'b1;
                    w_cmd.err  = w_err[15:0];
                end
            end
        end else if (w_dn_req) begin
            if (!r_f2_tag.low_open) begin
                w_cmd.res.count_load       = 1'b1;
                w_cmd.res.count_load_value = i_range_low;
                w_cmd.res.settled          = 1'b1;
            end else begin
                w_cmd.res.motion = epd_pkg::MOTION_DOWN;
                if (w_big) begin
                    w_cmd.res.drive_down = i_drive_ceiling;
                end else begin
                    w_cmd.prop = 1'b1;
                    w_cmd.err  = w_err[15:0];
                end
            end
        end else begin
            w_cmd.res.settled = 1'b1;
        end
    end

    assign o_push = r_f2_v && fe;
    assign o_cmd  = w_cmd;

endmodule

>>> rtl/epd_queue.sv
// ----------------------------------------------------------------------------
// epd_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  epd_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output epd_pkg::t_cmd o_data
);

    localparam int CNT_W = epd_pkg::QPTR_W + 1;

    epd_pkg::t_cmd                r_mem [epd_pkg::QUEUE_DEPTH];
    logic [epd_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [epd_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;

    assign o_full  = (r_count == CNT_W'(epd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/epd_back.sv
// ----------------------------------------------------------------------------
// epd_back
// Works out the proportional duty and holds the result word for the sink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  epd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  logic [15:0]   i_drive_floor,
    input  logic [15:0]   i_drive_ceiling,
    input  logic [15:0]   i_span,
    output logic          o_valid,
    input  logic          i_stall,
    output epd_pkg::t_res o_res
);

    localparam int TAG_W = $bits(epd_pkg::t_back_tag);

    logic                 be;
    logic                 r_b0_v;
    logic [31:0]          r_b0_prod;
    epd_pkg::t_back_tag   r_b0_tag;
    epd_pkg::t_back_tag   w_b0_tag;

    logic                 d2_v;
    logic [31:0]          d2_q;
    logic [TAG_W-1:0]     d2_tag;
    epd_pkg::t_back_tag   w_d2_tag;
    logic                 w_neg;
    logic [15:0]          w_duty;
    epd_pkg::t_res        n_res;

    logic                 r_out_v;
    epd_pkg::t_res        r_out_res;

    // the back advances unless the output word is held by the sink
    assign be    = !(r_out_v && i_stall);
    assign o_pop = be && !i_empty;

    always_comb begin
        w_b0_tag.res    = i_cmd.res;
        w_b0_tag.prop   = i_cmd.prop;
        w_b0_tag.dir_up = i_cmd.dir_up;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v <= 1'b0;
        end else if (be) begin
            r_b0_v <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            r_b0_prod <= i_cmd.err * epd_pkg::f_abs_diff(i_drive_ceiling, i_drive_floor);
            r_b0_tag  <= w_b0_tag;
        end
    end

    epd_div #(
        .NW (32),
        .DW (16),
        .TW (TAG_W)
    ) u_duty_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (be),
        .i_valid (r_b0_v),
        .i_num   (r_b0_prod),
        .i_den   (i_span),
        .i_tag   (r_b0_tag),
        .o_valid (d2_v),
        .o_quot  (d2_q),
        .o_tag   (d2_tag)
    );

    assign w_d2_tag = epd_pkg::t_back_tag'(d2_tag);
    // quotient is below |ceiling - floor|, so the duty lands between the two
    assign w_neg    = (i_drive_ceiling < i_drive_floor);
    assign w_duty   = w_neg ? (i_drive_floor - d2_q[15:0]) : (i_drive_floor + d2_q[15:0]);

    always_comb begin
        n_res = w_d2_tag.res;
        if (w_d2_tag.prop) begin
            if (w_d2_tag.dir_up) begin
                n_res.drive_up = w_duty;
            end else begin
                n_res.drive_down = w_duty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (be) begin
            r_out_v <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            r_out_res <= n_res;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out_res;

endmodule

>>> rtl/encoder_position_drive.sv
// ----------------------------------------------------------------------------
// encoder_position_drive
// Proportional position drive with deadband, saturation and limit homing.
// Throughput: one word per cycle when nothing stalls; the step scaling is a
// reciprocal multiply and the duty divider is pipelined one quotient bit per
// stage (32 stages).
// Reset: synchronous, active low; empties all stages and the queue and loads
// the registers with their defaults. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_position_drive #(
    parameter int POSITION_STEPS = 250
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_target_position,
    input  logic [15:0] i_encoder_count,
    input  logic        i_low_switch_open,
    input  logic        i_high_switch_open,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_drive_down,
    output logic [15:0] o_drive_up,
    output logic        o_count_load,
    output logic [15:0] o_count_load_value,
    output logic        o_settled,
    output logic [1:0]  o_motion,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]   r_range_low;
    logic [15:0]   r_range_high;
    logic [7:0]    r_deadband;
    logic [15:0]   r_drive_floor;
    logic [15:0]   r_drive_ceiling;
    logic [15:0]   r_homing_drive;

    logic [2:0]    w_reg_idx;
    logic          w_cfg_wr;
    logic [15:0]   w_span;

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    epd_pkg::t_cmd q_wdata;
    epd_pkg::t_cmd q_rdata;
    epd_pkg::t_res w_res;

    // configuration port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low     <= epd_pkg::RST_RANGE_LOW;
            r_range_high    <= epd_pkg::RST_RANGE_HIGH;
            r_deadband      <= epd_pkg::RST_DEADBAND;
            r_drive_floor   <= epd_pkg::RST_DRIVE_FLOOR;
            r_drive_ceiling <= epd_pkg::RST_DRIVE_CEILING;
            r_homing_drive  <= epd_pkg::RST_HOMING_DRIVE;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                epd_pkg::CFG_RANGE_LOW:     r_range_low     <= pwdata[15:0];
                epd_pkg::CFG_RANGE_HIGH:    r_range_high    <= pwdata[15:0];
                epd_pkg::CFG_DEADBAND:      r_deadband      <= pwdata[7:0];
                epd_pkg::CFG_DRIVE_FLOOR:   r_drive_floor   <= pwdata[15:0];
                epd_pkg::CFG_DRIVE_CEILING: r_drive_ceiling <= pwdata[15:0];
                epd_pkg::CFG_HOMING_DRIVE:  r_homing_drive  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            epd_pkg::CFG_RANGE_LOW:     prdata = {16'd0, r_range_low};
            epd_pkg::CFG_RANGE_HIGH:    prdata = {16'd0, r_range_high};
            epd_pkg::CFG_DEADBAND:      prdata = {24'd0, r_deadband};
            epd_pkg::CFG_DRIVE_FLOOR:   prdata = {16'd0, r_drive_floor};
            epd_pkg::CFG_DRIVE_CEILING: prdata = {16'd0, r_drive_ceiling};
            epd_pkg::CFG_HOMING_DRIVE:  prdata = {16'd0, r_homing_drive};
            default:                    prdata = 32'd0;
        endcase
    end

    assign w_span = epd_pkg::f_abs_diff(r_range_high, r_range_low);

    epd_front #(
        .POSITION_STEPS (POSITION_STEPS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in_valid),
        .o_stall            (o_in_stall),
        .i_target_position  (i_target_position),
        .i_encoder_count    (i_encoder_count),
        .i_low_switch_open  (i_low_switch_open),
        .i_high_switch_open (i_high_switch_open),
        .i_range_low        (r_range_low),
        .i_range_high       (r_range_high),
        .i_deadband         (r_deadband),
        .i_drive_ceiling    (r_drive_ceiling),
        .i_homing_drive     (r_homing_drive),
        .i_span             (w_span),
        .i_q_full           (q_full),
        .o_push             (q_push),
        .o_cmd              (q_wdata)
    );

    epd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    epd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_cmd           (q_rdata),
        .o_pop           (q_pop),
        .i_drive_floor   (r_drive_floor),
        .i_drive_ceiling (r_drive_ceiling),
        .i_span          (w_span),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_res           (w_res)
    );

    assign o_drive_down       = w_res.drive_down;
    assign o_drive_up         = w_res.drive_up;
    assign o_count_load       = w_res.count_load;
    assign o_count_load_value = w_res.count_load_value;
    assign o_settled          = w_res.settled;
    assign o_motion           = w_res.motion;

`include "encoder_position_drive_assert.svh"

    `EPD_ASSERT_IMPL(a_one_side_driven, o_out_valid, (o_drive_down == 16'd0) || (o_drive_up == 16'd0))
    `EPD_ASSERT_IMPL(a_settled_iff_stop, o_out_valid, o_settled == (o_motion == epd_pkg::MOTION_STOP))
    `EPD_ASSERT_IMPL(a_load_stops, o_out_valid && o_count_load, (o_drive_down == 16'd0) && (o_drive_up == 16'd0) && o_settled)
    `EPD_ASSERT_IMPL(a_load_value_idle, o_out_valid && !o_count_load, o_count_load_value == 16'd0)

endmodule
